[src/go_back_n_sender_core_defines.svh]
// ----------------------------------------------------------------------------
// go_back_n_sender_core_defines
// Assertion macros for the go-back-n sender core, used by gbn_back.
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_SENDER_CORE_DEFINES_SVH
`define GO_BACK_N_SENDER_CORE_DEFINES_SVH

// property checked on every clock edge outside reset
`define GBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define GBN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/gbn_pkg.sv]
// ----------------------------------------------------------------------------
// gbn_pkg
// Types and sizing constants for the go-back-n sender core.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // sequence space, window and data word
  localparam int SEQ_SPACE    = 16;
  localparam int WINDOW_SIZE  = 8;
  localparam int PAYLOAD_BITS = 32;

  localparam int SEQ_W = $clog2(SEQ_SPACE);
  // holds any count up to the sequence space or the window size
  localparam int LEN_W = $clog2(((SEQ_SPACE > WINDOW_SIZE) ? SEQ_SPACE : WINDOW_SIZE) + 1);

  // request codes on the input channel
  typedef enum logic [1:0] {
    REQ_SEND    = 2'd0,
    REQ_ACK     = 2'd1,
    REQ_TIMEOUT = 2'd2
  } req_type_t;

  // retransmission timer commands
  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_RESTART = 2'd2,
    TMR_STOP    = 2'd3
  } timer_cmd_t;

  // classified commands passed from front to back
  typedef enum logic [1:0] {
    CMD_SEND,
    CMD_ACK,
    CMD_TIMEOUT,
    CMD_IGNORE
  } cmd_op_t;

  // source of the packet data word in a result
  typedef enum logic [1:0] {
    PL_ZERO,
    PL_CMD,
    PL_STORE
  } pl_sel_t;

  typedef struct packed {
    cmd_op_t                 op;
    logic [SEQ_W-1:0]        ack_num;
    logic [PAYLOAD_BITS-1:0] payload;
  } cmd_t;

endpackage

[src/gbn_front.sv]
// ----------------------------------------------------------------------------
// gbn_front
// Input side: takes request transfers and classifies them into commands.
// ----------------------------------------------------------------------------
module gbn_front (
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     req_type,
  input  logic [gbn_pkg::PAYLOAD_BITS-1:0] payload,
  input  logic [gbn_pkg::SEQ_W-1:0]      ack_num,
  input  logic                           ack_ok,
  input  logic                           q_full,
  output logic                           q_push,
  output gbn_pkg::cmd_t                  q_cmd
);
  import gbn_pkg::*;

  // stall while the queue has no room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // classify the request; bad acks and unknown codes change nothing
  always_comb begin
    q_cmd.ack_num = ack_num;
    q_cmd.payload = payload;
    unique case (req_type)
      REQ_SEND:    q_cmd.op = CMD_SEND;
      REQ_ACK:     q_cmd.op = ack_ok ? CMD_ACK : CMD_IGNORE;
      REQ_TIMEOUT: q_cmd.op = CMD_TIMEOUT;
      default:     q_cmd.op = CMD_IGNORE;
    endcase
  end

endmodule

[src/gbn_queue.sv]
// ----------------------------------------------------------------------------
// gbn_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module gbn_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gbn_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output gbn_pkg::cmd_t head_cmd
);
  import gbn_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = entry[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_cmd;
  end

endmodule

[src/gbn_back.sv]
// ----------------------------------------------------------------------------
// gbn_back
// Window state, packet store, resend walker and the result register.
// ----------------------------------------------------------------------------
`include "go_back_n_sender_core_defines.svh"

module gbn_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  input  gbn_pkg::cmd_t                    cmd,
  output logic                             cmd_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             accepted,
  output logic                             pkt_valid,
  output logic [gbn_pkg::SEQ_W-1:0]        pkt_seq,
  output logic [gbn_pkg::PAYLOAD_BITS-1:0] pkt_payload,
  output logic [1:0]                       timer_cmd,
  output logic                             window_full,
  output logic                             last
);
  import gbn_pkg::*;

  localparam logic [SEQ_W:0] SEQ_LEN = (SEQ_W + 1)'(SEQ_SPACE);
  localparam logic [SEQ_W:0] WIN_MOD = (SEQ_W + 1)'(WINDOW_SIZE % SEQ_SPACE);
  localparam logic [LEN_W-1:0] WIN_LEN = LEN_W'(WINDOW_SIZE);
  localparam logic [LEN_W-1:0] SPACE_LEN = LEN_W'(SEQ_SPACE);
  localparam logic [LEN_W-1:0] ONE_LEN = LEN_W'(1);

  // window state
  logic [SEQ_W-1:0] base, base_next;
  logic [SEQ_W-1:0] next_seq, next_seq_next;
  logic             full, full_next;

  // resend walker
  logic             walking, walking_next;
  logic [SEQ_W-1:0] walk_seq, walk_seq_next;
  logic [LEN_W-1:0] walk_left, walk_left_next;

  // packet store
  logic [PAYLOAD_BITS-1:0] store [SEQ_SPACE];
  logic                    store_we;

  // result being built this cycle
  logic             load, load_ok;
  logic             res_acc, res_pkt, res_full, res_last;
  logic [SEQ_W-1:0] res_seq;
  timer_cmd_t       res_timer;
  pl_sel_t          res_sel;

  // derived window values
  logic [SEQ_W:0]   base_plus_sum, ack_sum, span;
  logic [SEQ_W-1:0] base_plus_w, ack_base;
  logic [LEN_W-1:0] outstanding, resend_len;

  function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
    logic [SEQ_W:0] t;
    t = {1'b0, s} + (SEQ_W + 1)'(1);
    seq_inc = (t == SEQ_LEN) ? '0 : t[SEQ_W-1:0];
  endfunction

  // window limit, new base on an ack and the resend length
  always_comb begin
    base_plus_sum = {1'b0, base} + WIN_MOD;
    base_plus_w   = (base_plus_sum >= SEQ_LEN) ? SEQ_W'(base_plus_sum - SEQ_LEN)
                                               : base_plus_sum[SEQ_W-1:0];
    ack_sum  = {1'b0, cmd.ack_num} + (SEQ_W + 1)'(1);
    ack_base = (ack_sum >= SEQ_LEN) ? SEQ_W'(ack_sum - SEQ_LEN) : ack_sum[SEQ_W-1:0];
    span     = (next_seq >= base) ? ({1'b0, next_seq} - {1'b0, base})
                                  : ({1'b0, next_seq} + SEQ_LEN - {1'b0, base});
    outstanding = LEN_W'(span);
    if (outstanding == '0 && full) outstanding = SPACE_LEN;
    resend_len = (outstanding > WIN_LEN) ? WIN_LEN : outstanding;
  end

  assign load_ok = !out_valid || !out_stall;

  // command execution and result selection
  always_comb begin
    base_next      = base;
    next_seq_next  = next_seq;
    full_next      = full;
    walking_next   = walking;
    walk_seq_next  = walk_seq;
    walk_left_next = walk_left;
    cmd_pop   = 1'b0;
    load      = 1'b0;
    store_we  = 1'b0;
    res_acc   = 1'b0;
    res_pkt   = 1'b0;
    res_full  = full;
    res_last  = 1'b1;
    res_seq   = '0;
    res_timer = TMR_NONE;
    res_sel   = PL_ZERO;
    if (walking) begin
      if (load_ok) begin
        load           = 1'b1;
        res_pkt        = 1'b1;
        res_seq        = walk_seq;
        res_sel        = PL_STORE;
        res_last       = (walk_left == ONE_LEN);
        walk_seq_next  = seq_inc(walk_seq);
        walk_left_next = walk_left - ONE_LEN;
        if (walk_left == ONE_LEN) walking_next = 1'b0;
      end
    end else if (cmd_valid && load_ok) begin
      cmd_pop = 1'b1;
      load    = 1'b1;
      unique case (cmd.op)
        CMD_SEND: begin
          if (!full) begin
            store_we      = 1'b1;
            res_acc       = 1'b1;
            res_pkt       = 1'b1;
            res_seq       = next_seq;
            res_sel       = PL_CMD;
            res_timer     = (base == next_seq) ? TMR_START : TMR_NONE;
            next_seq_next = seq_inc(next_seq);
            full_next     = (next_seq_next == base_plus_w);
            res_full      = full_next;
          end
        end
        CMD_ACK: begin
          base_next = ack_base;
          full_next = 1'b0;
          res_full  = 1'b0;
          res_timer = (ack_base != next_seq) ? TMR_RESTART : TMR_STOP;
        end
        CMD_TIMEOUT: begin
          res_timer = TMR_RESTART;
          if (resend_len != '0) begin
            res_pkt  = 1'b1;
            res_seq  = base;
            res_sel  = PL_STORE;
            res_last = (resend_len == ONE_LEN);
            if (resend_len != ONE_LEN) begin
              walking_next   = 1'b1;
              walk_seq_next  = seq_inc(base);
              walk_left_next = resend_len - ONE_LEN;
            end
          end
        end
        CMD_IGNORE: begin
          res_full = full;
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      next_seq  <= '0;
      full      <= 1'b0;
      walking   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      base     <= base_next;
      next_seq <= next_seq_next;
      full     <= full_next;
      walking  <= walking_next;
      if (load)            out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    walk_seq  <= walk_seq_next;
    walk_left <= walk_left_next;
  end

  // packet store write
  always_ff @(posedge clk) begin
    if (store_we) store[next_seq] <= cmd.payload;
  end

  // result register; a stored word is read straight into it
  always_ff @(posedge clk) begin
    if (load) begin
      accepted    <= res_acc;
      pkt_valid   <= res_pkt;
      pkt_seq     <= res_seq;
      timer_cmd   <= res_timer;
      window_full <= res_full;
      last        <= res_last;
      unique case (res_sel)
        PL_CMD:   pkt_payload <= cmd.payload;
        PL_STORE: pkt_payload <= store[res_seq];
        default:  pkt_payload <= '0;
      endcase
    end
  end

  `GBN_ASSERT(a_full_at_limit, full |-> (next_seq == base_plus_w), "full flag off the window limit")
  `GBN_ASSERT(a_no_pop_in_walk, walking |-> !cmd_pop, "command taken during a resend")
  `GBN_ASSERT(a_walk_ends, (walking && load && walk_left == ONE_LEN) |=> !walking, "resend overran")
  `GBN_ASSERT(a_accept_packet, (out_valid && accepted) |-> pkt_valid, "accepted send with no packet")
  `GBN_ASSERT_ALWAYS(a_reset_idle, rst |=> (!out_valid && !walking && !full), "busy after reset")

endmodule

[src/go_back_n_sender_core.sv]
// ----------------------------------------------------------------------------
// go_back_n_sender_core
// Go-back-n sender window: sends, cumulative acks and timeout resends.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with req_type, payload, ack_num, ack_ok;
//   a request is a send, an ack (ack_ok marks a good checksum) or a timeout
//   output channel: out_valid / out_stall with one result per transfer;
//   last marks the final result of a request
//   a send, an ack, a bad ack or an unknown code gives one result; a timeout
//   gives one result per outstanding packet, up to WINDOW_SIZE (one if none
//   is outstanding), one per cycle unless out_stall holds them, read from the
//   packet store; with the queue empty and no resend running, a request goes
//   into the queue, then its first result into the result register; a
//   two-entry queue sits between the request decoder and the window logic,
//   so requests keep coming in while a result waits or a resend runs
//   reset clears the window (base and next sequence zero, not full), the
//   queue and the result valid flag; the packet store is left as it is
//   while out_stall is high with a result waiting, the result holds and no
//   further command is executed; in_stall rises once the queue is full
// ----------------------------------------------------------------------------
module go_back_n_sender_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       req_type,
  input  logic [gbn_pkg::PAYLOAD_BITS-1:0] payload,
  input  logic [gbn_pkg::SEQ_W-1:0]        ack_num,
  input  logic                             ack_ok,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             accepted,
  output logic                             pkt_valid,
  output logic [gbn_pkg::SEQ_W-1:0]        pkt_seq,
  output logic [gbn_pkg::PAYLOAD_BITS-1:0] pkt_payload,
  output logic [1:0]                       timer_cmd,
  output logic                             window_full,
  output logic                             last
);
  import gbn_pkg::*;

  logic q_full, q_push, q_pop, head_valid;
  cmd_t push_cmd, head_cmd;

  // request decode
  gbn_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .payload  (payload),
    .ack_num  (ack_num),
    .ack_ok   (ack_ok),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // command queue
  gbn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // window logic and result register
  gbn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (head_valid),
    .cmd         (head_cmd),
    .cmd_pop     (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .accepted    (accepted),
    .pkt_valid   (pkt_valid),
    .pkt_seq     (pkt_seq),
    .pkt_payload (pkt_payload),
    .timer_cmd   (timer_cmd),
    .window_full (window_full),
    .last        (last)
  );

endmodule

[dv/go_back_n_sender_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// go_back_n_sender_core_test
// Drives sends, acks, bad acks, unknown codes and timeouts into the sender
// window and checks every result against a window model kept in step with
// the accepted requests. A directed table opens the run, then random traffic
// built mostly from in-window acks and sends, with random idling on both
// channels.
// ----------------------------------------------------------------------------
module go_back_n_sender_core_test;
  import gbn_pkg::*;

  // request code that the block must treat as a no-op
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_REQS = 153;

  typedef struct packed {
    logic                    accepted;
    logic                    pkt_valid;
    logic [SEQ_W-1:0]        seq;
    logic [PAYLOAD_BITS-1:0] data;
    timer_cmd_t              tcmd;
    logic                    full;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic [1:0]              req;
    logic [PAYLOAD_BITS-1:0] data;
    logic [SEQ_W-1:0]        ack;
    logic                    ok;
    logic                    typed;
    result_t                 want;
  } stim_row_t;

  localparam result_t UNTYPED = '0;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              req_type = REQ_SEND;
  logic [PAYLOAD_BITS-1:0] payload = '0;
  logic [SEQ_W-1:0]        ack_num = '0;
  logic                    ack_ok = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    accepted;
  logic                    pkt_valid;
  logic [SEQ_W-1:0]        pkt_seq;
  logic [PAYLOAD_BITS-1:0] pkt_payload;
  logic [1:0]              timer_cmd;
  logic                    window_full;
  logic                    last;

  // window model state
  logic [SEQ_W-1:0]        win_base = '0;
  logic [SEQ_W-1:0]        seq_next = '0;
  logic                    win_full = 1'b0;
  logic [PAYLOAD_BITS-1:0] sent_words [SEQ_SPACE];

  result_t expected_pkts[$];
  int      err_count = 0;
  bit      steady_in = 1'b0;
  bit      steady_out = 1'b0;
  int      out_hold = 0;

  // opening table: the first eight sends and the second eight fill every
  // store entry before any stray ack can widen the resend range
  stim_row_t dir_rows [27] = '{
    // timeout with nothing outstanding
    '{REQ_TIMEOUT, 32'h0, 4'h0, 1'b0, 1'b1,
      '{1'b0, 1'b0, 4'h0, 32'h0, TMR_RESTART, 1'b0, 1'b1}},
    // good ack that leaves the window empty
    '{REQ_ACK, 32'h0, 4'hf, 1'b1, 1'b1,
      '{1'b0, 1'b0, 4'h0, 32'h0, TMR_STOP, 1'b0, 1'b1}},
    // bad checksum ack is ignored
    '{REQ_ACK, 32'hffffffff, 4'hf, 1'b0, 1'b1,
      '{1'b0, 1'b0, 4'h0, 32'h0, TMR_NONE, 1'b0, 1'b1}},
    // unknown request code
    '{REQ_UNUSED, 32'hffffffff, 4'hf, 1'b1, 1'b1,
      '{1'b0, 1'b0, 4'h0, 32'h0, TMR_NONE, 1'b0, 1'b1}},
    // first send into an empty window starts the timer
    '{REQ_SEND, 32'h0, 4'h0, 1'b0, 1'b1,
      '{1'b1, 1'b1, 4'h0, 32'h0, TMR_START, 1'b0, 1'b1}},
    '{REQ_SEND, 32'hffffffff, 4'hf, 1'b1, 1'b0, UNTYPED},
    '{REQ_SEND, 32'ha5a5a5a5, 4'h5, 1'b0, 1'b0, UNTYPED},
    '{REQ_SEND, 32'h5a5a5a5a, 4'ha, 1'b1, 1'b0, UNTYPED},
    '{REQ_SEND, 32'h0000ffff, 4'h0, 1'b0, 1'b0, UNTYPED},
    '{REQ_SEND, 32'hffff0000, 4'hf, 1'b0, 1'b0, UNTYPED},
    '{REQ_SEND, 32'h80000001, 4'h1, 1'b1, 1'b0, UNTYPED},
    // eighth send fills the window
    '{REQ_SEND, 32'h7ffffffe, 4'h7, 1'b0, 1'b0, UNTYPED},
    // send refused while full
    '{REQ_SEND, 32'h12345678, 4'h0, 1'b0, 1'b1,
      '{1'b0, 1'b0, 4'h0, 32'h0, TMR_NONE, 1'b1, 1'b1}},
    // bad ack while full keeps the flag
    '{REQ_ACK, 32'h0, 4'h3, 1'b0, 1'b1,
      '{1'b0, 1'b0, 4'h0, 32'h0, TMR_NONE, 1'b1, 1'b1}},
    // full window resent
    '{REQ_TIMEOUT, 32'h0, 4'h0, 1'b0, 1'b0, UNTYPED},
    '{REQ_ACK, 32'h0, 4'h7, 1'b1, 1'b0, UNTYPED},
    '{REQ_SEND, 32'hdeadbeef, 4'h0, 1'b0, 1'b0, UNTYPED},
    '{REQ_SEND, 32'h01234567, 4'h0, 1'b0, 1'b0, UNTYPED},
    '{REQ_SEND, 32'h89abcdef, 4'h0, 1'b0, 1'b0, UNTYPED},
    '{REQ_SEND, 32'h0f0f0f0f, 4'h0, 1'b0, 1'b0, UNTYPED},
    '{REQ_SEND, 32'hf0f0f0f0, 4'h0, 1'b0, 1'b0, UNTYPED},
    '{REQ_SEND, 32'h33333333, 4'h0, 1'b0, 1'b0, UNTYPED},
    '{REQ_SEND, 32'hcccccccc, 4'h0, 1'b0, 1'b0, UNTYPED},
    '{REQ_SEND, 32'h00000001, 4'h0, 1'b0, 1'b0, UNTYPED},
    // ack outside the window leaves twelve outstanding
    '{REQ_ACK, 32'h0, 4'h3, 1'b1, 1'b0, UNTYPED},
    // resend capped at the window size
    '{REQ_TIMEOUT, 32'h0, 4'h0, 1'b0, 1'b0, UNTYPED},
    '{REQ_ACK, 32'h0, 4'hf, 1'b1, 1'b0, UNTYPED}
  };

  go_back_n_sender_core uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .payload    (payload),
    .ack_num    (ack_num),
    .ack_ok     (ack_ok),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .accepted   (accepted),
    .pkt_valid  (pkt_valid),
    .pkt_seq    (pkt_seq),
    .pkt_payload(pkt_payload),
    .timer_cmd  (timer_cmd),
    .window_full(window_full),
    .last       (last)
  );

  always #6 clk = ~clk;

  // window model: applies one accepted request and queues its results
  task automatic advance_window(input logic [1:0] req, input logic [PAYLOAD_BITS-1:0] data,
                                input logic [SEQ_W-1:0] ack, input logic ok);
    result_t r;
    int      span;
    r = '0;
    r.tcmd = TMR_NONE;
    r.last = 1'b1;
    case (req)
      REQ_SEND: begin
        if (!win_full) begin
          sent_words[seq_next] = data;
          r.accepted  = 1'b1;
          r.pkt_valid = 1'b1;
          r.seq       = seq_next;
          r.data      = data;
          r.tcmd      = (win_base == seq_next) ? TMR_START : TMR_NONE;
          seq_next    = seq_next + 1'b1;
          if (seq_next == SEQ_W'(win_base + WINDOW_SIZE))
            win_full = 1'b1;
        end
        r.full = win_full;
        expected_pkts.push_back(r);
      end
      REQ_ACK: begin
        if (ok) begin
          win_base = ack + 1'b1;
          win_full = 1'b0;
          r.tcmd   = (win_base != seq_next) ? TMR_RESTART : TMR_STOP;
        end
        r.full = win_full;
        expected_pkts.push_back(r);
      end
      REQ_TIMEOUT: begin
        span = SEQ_W'(seq_next - win_base);
        if (span == 0 && win_full)
          span = SEQ_SPACE;
        if (span > WINDOW_SIZE)
          span = WINDOW_SIZE;
        r.full = win_full;
        if (span == 0) begin
          r.tcmd = TMR_RESTART;
          expected_pkts.push_back(r);
        end else begin
          // oldest unacknowledged first, timer restart on the first only
          for (int i = 0; i < span; i++) begin
            r.pkt_valid = 1'b1;
            r.seq       = win_base + SEQ_W'(i);
            r.data      = sent_words[r.seq];
            r.tcmd      = (i == 0) ? TMR_RESTART : TMR_NONE;
            r.last      = (i == span - 1);
            expected_pkts.push_back(r);
          end
        end
      end
      default: begin
        r.full = win_full;
        expected_pkts.push_back(r);
      end
    endcase
  endtask

  // idle for a drawn gap, hold the request until the transfer, then model it
  task automatic offer_request(input logic [1:0] req, input logic [PAYLOAD_BITS-1:0] data,
                               input logic [SEQ_W-1:0] ack, input logic ok);
    int gap;
    if ($urandom_range(0, 15) == 0)
      steady_in = !steady_in;
    gap = steady_in ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    payload  <= data;
    ack_num  <= ack;
    ack_ok   <= ok;
    do @(posedge clk); while (in_stall);
    advance_window(req, data, ack, ok);
  endtask

  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  // result side: compare each transfer, then draw the stall for the next one
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_pkts.size() == 0) begin
          $display("%0t: result with nothing expected, seq %0h payload %0h", $time,
                   pkt_seq, pkt_payload);
          err_count++;
        end else begin
          want = expected_pkts.pop_front();
          flag_field("accepted", want.accepted, accepted);
          flag_field("pkt_valid", want.pkt_valid, pkt_valid);
          flag_field("pkt_seq", want.seq, pkt_seq);
          flag_field("pkt_payload", want.data, pkt_payload);
          flag_field("timer_cmd", want.tcmd, timer_cmd);
          flag_field("window_full", want.full, window_full);
          flag_field("last", want.last, last);
        end
        if ($urandom_range(0, 15) == 0)
          steady_out = !steady_out;
        out_hold = steady_out ? 0 : $urandom_range(0, 6);
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus
  initial begin
    int                      done_reqs;
    int                      pick;
    int                      span;
    logic [1:0]              req_v;
    logic [PAYLOAD_BITS-1:0] data_v;
    logic [SEQ_W-1:0]        ack_v;
    logic                    ok_v;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      offer_request(dir_rows[i].req, dir_rows[i].data, dir_rows[i].ack, dir_rows[i].ok);
      if (dir_rows[i].typed)
        expected_pkts[expected_pkts.size() - 1] = dir_rows[i].want;
    end

    // random traffic; every store entry is written by now, so stray acks are safe
    done_reqs = 0;
    while (done_reqs < RANDOM_REQS) begin
      pick    = $urandom_range(0, 99);
      data_v  = $urandom;
      ack_v   = SEQ_W'($urandom_range(0, SEQ_SPACE - 1));
      ok_v    = 1'($urandom_range(0, 1));
      span    = SEQ_W'(seq_next - win_base);
      if (pick < 45 || (pick < 65 && span == 0)) begin
        req_v = REQ_SEND;
        case ($urandom_range(0, 7))
          0: data_v = '1;
          1: data_v = '0;
          default: ;
        endcase
      end else if (pick < 65) begin
        // cumulative ack somewhere inside the outstanding range
        req_v = REQ_ACK;
        ok_v  = 1'b1;
        ack_v = win_base + SEQ_W'($urandom_range(0, span - 1));
      end else if (pick < 77) begin
        req_v = REQ_TIMEOUT;
      end else if (pick < 87) begin
        req_v = REQ_ACK;
        ok_v  = 1'b0;
      end else if (pick < 93) begin
        // ack number anywhere, window or not
        req_v = REQ_ACK;
        ok_v  = 1'b1;
      end else begin
        req_v = REQ_UNUSED;
      end
      offer_request(req_v, data_v, ack_v, ok_v);
      done_reqs++;
    end
    in_valid <= 1'b0;

    while (expected_pkts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("go_back_n_sender_core_test: done, clean");
    end else begin
      $display("go_back_n_sender_core_test: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_pkts.size());
    $display("go_back_n_sender_core_test: done, errors");
    $finish;
  end

endmodule
